/* rtl/core/lpht_pkg.sv */
package lpht_pkg;

	// Defaults for the top level parameters
	localparam int TABLE_BITS_DEF  = 10;
	localparam int VALUE_WIDTH_DEF = 32;

	// Field widths
	localparam int OP_W   = 2;
	localparam int KEY_W  = 64;
	localparam int WORD_W = 32;
	localparam int HALF_W = KEY_W / 2;

	// Fibonacci hash multiplier
	localparam logic [KEY_W-1:0] GOLDEN_MULT = 64'h9E3779B97F4A7C15;

	// Operation codes
	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
	localparam logic [OP_W-1:0] OP_DELETE = 2'd2;
	localparam logic [OP_W-1:0] OP_NONE   = 2'd3;

	// Slot status codes
	localparam logic [1:0] SLOT_EMPTY    = 2'd0;
	localparam logic [1:0] SLOT_OCCUPIED = 2'd1;
	localparam logic [1:0] SLOT_DELETED  = 2'd2;

	// Result status
	localparam logic STATUS_OK   = 1'b0;
	localparam logic STATUS_FAIL = 1'b1;

	typedef struct packed {
		logic [OP_W-1:0]   operation;
		logic [KEY_W-1:0]  key;
		logic [WORD_W-1:0] value;
	} lpht_req_t;

	typedef struct packed {
		logic              status;
		logic [WORD_W-1:0] found_value;
	} lpht_rsp_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MUL0,
		ST_MUL1,
		ST_MUL2,
		ST_MUL3,
		ST_HOME,
		ST_PROBE
	} lpht_state_t;

endpackage

/* rtl/core/linear_probe_hash_table.sv */
// Open-addressing hash table with linear probing and Fibonacci hashing. A transaction is
// accepted when start is high and busy is low; its result appears on rsp for exactly one
// cycle with done high and cannot be held off, so the receiver must take it then. After
// acceptance the states ST_MUL0 to ST_MUL3 run the 64-bit hash through one shared
// 32x32 multiplier as three partial products, the state ST_HOME forms the home slot, and
// the probe then walks one slot per cycle through the single read port of the slot
// memories, examining from 1 up to 2^TABLE_BITS slots before the result strobe. An unused
// operation code raises a failure strobe in the cycle right after the accepting edge.
// After reset the block sweeps all 2^TABLE_BITS slots of the status memory to empty, one
// slot per cycle, with busy held high.
module linear_probe_hash_table #(
	parameter int TABLE_BITS  = lpht_pkg::TABLE_BITS_DEF,
	parameter int VALUE_WIDTH = lpht_pkg::VALUE_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  lpht_pkg::lpht_req_t req,
	output logic               done,
	output lpht_pkg::lpht_rsp_t rsp
);
	import lpht_pkg::*;

	localparam int SLOT_COUNT = 1 << TABLE_BITS;
	localparam int STORE_W    = (VALUE_WIDTH < WORD_W) ? VALUE_WIDTH : WORD_W;

	lpht_state_t state_q, state_d;

	// Operation registers
	logic [OP_W-1:0]    op_q;
	logic [KEY_W-1:0]   key_q;
	logic [STORE_W-1:0] value_q;

	// Hash datapath
	logic [HALF_W-1:0] mul_a, mul_b;
	logic [KEY_W-1:0]  prod_q;
	logic [HALF_W-1:0] hi_q;

	// Probe state
	logic [TABLE_BITS-1:0] pos_q, steps_q, del_pos_q, clr_q;
	logic                  have_del_q;
	logic                  rec_del;

	// Slot memories and registered read data
	logic [1:0]         st_mem  [SLOT_COUNT];
	logic [KEY_W-1:0]   key_mem [SLOT_COUNT];
	logic [STORE_W-1:0] val_mem [SLOT_COUNT];
	logic [1:0]         st_rd_q;
	logic [KEY_W-1:0]   key_rd_q;
	logic [STORE_W-1:0] val_rd_q;

	logic [TABLE_BITS-1:0] rd_addr;
	logic                  st_we, kv_we;
	logic [TABLE_BITS-1:0] st_wa;
	logic [1:0]            st_wd;

	// Result
	logic              fin;
	logic              fin_status;
	logic [WORD_W-1:0] fin_found;
	logic              done_q;
	lpht_rsp_t         rsp_q;

	logic accept;
	logic is_empty, is_occ, is_match, is_del, lap_end;

	assign accept   = start && (state_q == ST_IDLE);
	assign busy     = (state_q != ST_IDLE);
	assign done     = done_q;
	assign rsp      = rsp_q;

	assign is_empty = (st_rd_q == SLOT_EMPTY);
	assign is_occ   = (st_rd_q == SLOT_OCCUPIED);
	assign is_match = is_occ && (key_rd_q == key_q);
	assign is_del   = !is_empty && !is_occ;
	assign lap_end  = &steps_q;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and control
	always_comb begin
		state_d    = state_q;
		mul_a      = key_q[HALF_W-1:0];
		mul_b      = GOLDEN_MULT[HALF_W-1:0];
		rd_addr    = pos_q + TABLE_BITS'(1);
		st_we      = 1'b0;
		kv_we      = 1'b0;
		st_wa      = pos_q;
		st_wd      = SLOT_OCCUPIED;
		rec_del    = 1'b0;
		fin        = 1'b0;
		fin_status = STATUS_FAIL;
		fin_found  = '0;
		unique case (state_q)
			ST_CLEAR: begin
				st_we = 1'b1;
				st_wa = clr_q;
				st_wd = SLOT_EMPTY;
				if (&clr_q) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					if (req.operation == OP_NONE) begin
						fin = 1'b1;
					end else begin
						state_d = ST_MUL0;
					end
				end
			end
			ST_MUL0: begin
				state_d = ST_MUL1;
			end
			ST_MUL1: begin
				mul_a   = key_q[KEY_W-1:HALF_W];
				state_d = ST_MUL2;
			end
			ST_MUL2: begin
				mul_b   = GOLDEN_MULT[KEY_W-1:HALF_W];
				state_d = ST_MUL3;
			end
			ST_MUL3: begin
				state_d = ST_HOME;
			end
			ST_HOME: begin
				rd_addr = hi_q[HALF_W-1 -: TABLE_BITS];
				state_d = ST_PROBE;
			end
			ST_PROBE: begin
				if (op_q == OP_INSERT) begin
					// a matching key is updated in place, even on the last slot of a lap
					if (is_match) begin
						fin        = 1'b1;
						fin_status = STATUS_OK;
						st_we      = 1'b1;
						kv_we      = 1'b1;
					end else if (is_empty || (lap_end && (have_del_q || is_del))) begin
						fin        = 1'b1;
						fin_status = STATUS_OK;
						st_we      = 1'b1;
						kv_we      = 1'b1;
						st_wa      = have_del_q ? del_pos_q : pos_q;
					end else if (lap_end) begin
						fin = 1'b1;
					end else begin
						rec_del = is_del && !have_del_q;
					end
				end else begin
					if (is_match) begin
						fin        = 1'b1;
						fin_status = STATUS_OK;
						if (op_q == OP_LOOKUP) begin
							fin_found[STORE_W-1:0] = val_rd_q;
						end else begin
							st_we = 1'b1;
							st_wd = SLOT_DELETED;
						end
					end else if (is_empty || lap_end) begin
						fin = 1'b1;
					end
				end
				if (fin) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control registers of the probe and the clearing sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= '0;
			have_del_q <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			done_q <= fin;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + TABLE_BITS'(1);
			end
			if (state_q == ST_HOME) begin
				have_del_q <= 1'b0;
			end else if (rec_del) begin
				have_del_q <= 1'b1;
			end
		end
	end

	// Payload registers: operation, hash accumulation, probe position
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= req.operation;
			key_q   <= req.key;
			value_q <= req.value[STORE_W-1:0];
		end
		prod_q <= mul_a * mul_b;
		unique case (state_q)
			ST_MUL1:            hi_q <= prod_q[KEY_W-1:HALF_W];
			ST_MUL2, ST_MUL3:   hi_q <= hi_q + prod_q[HALF_W-1:0];
			default:            hi_q <= hi_q;
		endcase
		if (state_q == ST_HOME) begin
			pos_q   <= rd_addr;
			steps_q <= '0;
		end else if (state_q == ST_PROBE) begin
			pos_q   <= rd_addr;
			steps_q <= steps_q + TABLE_BITS'(1);
		end
		if (rec_del) begin
			del_pos_q <= pos_q;
		end
		if (fin) begin
			rsp_q.status      <= fin_status;
			rsp_q.found_value <= fin_found;
		end
	end

	// Slot memories: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (st_we) begin
			st_mem[st_wa] <= st_wd;
		end
		if (kv_we) begin
			key_mem[st_wa] <= key_q;
			val_mem[st_wa] <= value_q;
		end
		st_rd_q  <= st_mem[rd_addr];
		key_rd_q <= key_mem[rd_addr];
		val_rd_q <= val_mem[rd_addr];
	end

endmodule

/* rtl/core/lpht_checker.sv */
module lpht_props (
	input logic                clk,
	input logic                arst_n,
	input logic                start,
	input logic                busy,
	input lpht_pkg::lpht_req_t req,
	input logic                done,
	input lpht_pkg::lpht_rsp_t rsp
);
	import lpht_pkg::*;

	// A real operation keeps the block busy past acceptance
	a_busy_after_op: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (req.operation != OP_NONE)) |=> busy)
		else $error("block not busy after accepting an operation");

	// An unused code fails at once
	a_none_fails: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (req.operation == OP_NONE)) |=> (done && rsp.status))
		else $error("unused operation code did not fail next cycle");

	// A result is shown only while the block is idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	// A returned value only comes with a hit
	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (rsp.found_value != '0)) |-> (rsp.status == STATUS_OK))
		else $error("nonzero found_value on a failed transaction");

endmodule

bind linear_probe_hash_table lpht_props u_lpht_props (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.req    (req),
	.done   (done),
	.rsp    (rsp)
);

/* tb/lpht_checker.sv */
`timescale 1ns / 100ps

// Watches both channels of the hash table, keeps a shadow copy of the slot store
// and compares every result strobe against the oldest predicted response.
module lpht_checker #(
	parameter int TABLE_BITS  = lpht_pkg::TABLE_BITS_DEF,
	parameter int VALUE_WIDTH = lpht_pkg::VALUE_WIDTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                busy,
	input  lpht_pkg::lpht_req_t req,
	input  logic                done,
	input  lpht_pkg::lpht_rsp_t rsp,
	output int                  mismatches,
	output int                  outstanding,
	output int                  checked,
	output int                  rejects
);

	import lpht_pkg::*;

	localparam int SLOTS = 1 << TABLE_BITS;
	localparam logic [WORD_W-1:0] VALUE_MASK = (VALUE_WIDTH >= WORD_W) ? {WORD_W{1'b1}} :
		WORD_W'((64'd1 << VALUE_WIDTH) - 64'd1);

	// Shadow slot store
	logic [1:0]        shadow_status [SLOTS];
	logic [KEY_W-1:0]  shadow_key    [SLOTS];
	logic [WORD_W-1:0] shadow_value  [SLOTS];

	// Responses owed by the block, oldest first
	lpht_rsp_t pending_rsp [$];

	int n_bad;
	int n_done;
	int n_full;

	task automatic report_mismatch(input string what, input logic [63:0] want,
			input logic [63:0] got);
		$display("%0t ns: mismatch on %s: expected %0h, got %0h", $time, what, want, got);
		n_bad++;
	endtask

	// Fibonacci hash: top TABLE_BITS bits of the 64-bit product
	function automatic int unsigned home_slot_of(input logic [KEY_W-1:0] k);
		logic [KEY_W-1:0] prod;
		prod = k * GOLDEN_MULT;
		return 32'(prod >> (KEY_W - TABLE_BITS));
	endfunction

	// Probe for an occupied slot holding k; -1 when absent
	function automatic int find_slot(input logic [KEY_W-1:0] k);
		int unsigned pos;
		pos = home_slot_of(k);
		for (int n = 0; n < SLOTS; n++) begin
			if (shadow_status[pos] == SLOT_EMPTY)
				return -1;
			if (shadow_status[pos] == SLOT_OCCUPIED && shadow_key[pos] == k)
				return int'(pos);
			pos = (pos + 1) % SLOTS;
		end
		return -1;
	endfunction

	// Apply one transaction to the shadow store and form its response
	task automatic apply_op(input lpht_req_t r, output lpht_rsp_t e);
		int          hit;
		int unsigned pos;
		int unsigned target;
		int unsigned del_pos;
		bit          have_slot;
		bit          del_seen;
		e.status      = STATUS_FAIL;
		e.found_value = '0;
		have_slot     = 1'b0;
		del_seen      = 1'b0;
		target        = 0;
		del_pos       = 0;
		case (r.operation)
			OP_INSERT: begin
				pos = home_slot_of(r.key);
				for (int n = 0; n < SLOTS; n++) begin
					if (shadow_status[pos] == SLOT_EMPTY) begin
						have_slot = 1'b1;
						target    = pos;
						break;
					end
					if (shadow_status[pos] == SLOT_OCCUPIED) begin
						// same key: update in place, even past a deleted slot
						if (shadow_key[pos] == r.key) begin
							have_slot = 1'b1;
							del_seen  = 1'b0;
							target    = pos;
							break;
						end
					end else if (!del_seen) begin
						del_seen = 1'b1;
						del_pos  = pos;
					end
					pos = (pos + 1) % SLOTS;
				end
				if (del_seen) begin
					have_slot = 1'b1;
					target    = del_pos;
				end
				if (have_slot) begin
					shadow_key[target]    = r.key;
					shadow_value[target]  = r.value & VALUE_MASK;
					shadow_status[target] = SLOT_OCCUPIED;
					e.status              = STATUS_OK;
				end else begin
					n_full++;
				end
			end
			OP_LOOKUP: begin
				hit = find_slot(r.key);
				if (hit >= 0) begin
					e.status      = STATUS_OK;
					e.found_value = shadow_value[hit] & VALUE_MASK;
				end
			end
			OP_DELETE: begin
				hit = find_slot(r.key);
				if (hit >= 0) begin
					shadow_status[hit] = SLOT_DELETED;
					shadow_key[hit]    = '0;
					shadow_value[hit]  = '0;
					e.status           = STATUS_OK;
				end
			end
			default: ;
		endcase
	endtask

	// Check strobed results first, then predict the newly accepted transaction
	always @(posedge clk) begin
		lpht_rsp_t want;
		lpht_rsp_t owed;
		if (!arst_n) begin
			for (int s = 0; s < SLOTS; s++)
				shadow_status[s] = SLOT_EMPTY;
			pending_rsp.delete();
		end else begin
			if (done) begin
				if (pending_rsp.size() == 0) begin
					report_mismatch("result with no transaction pending", '0, 64'(rsp));
				end else begin
					want = pending_rsp.pop_front();
					if (rsp.status !== want.status)
						report_mismatch("status", 64'(want.status), 64'(rsp.status));
					if (rsp.found_value !== want.found_value)
						report_mismatch("found_value", 64'(want.found_value),
							64'(rsp.found_value));
					n_done++;
				end
			end
			if (start && !busy) begin
				apply_op(req, owed);
				pending_rsp.push_back(owed);
			end
		end
		mismatches  <= n_bad;
		outstanding <= pending_rsp.size();
		checked     <= n_done;
		rejects     <= n_full;
	end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps

// Stimulus and verdict for the linear probing hash table
module tb_top;

	import lpht_pkg::*;

	localparam int TBITS        = TABLE_BITS_DEF;
	localparam int VBITS        = VALUE_WIDTH_DEF;
	localparam int SLOTS        = 1 << TBITS;
	localparam int RANDOM_ITEMS = 576;
	localparam int CALM_ITEMS   = 100;
	localparam int POOL_SIZE    = 64;

	logic      clk;
	logic      arst_n;
	logic      start;
	logic      busy;
	logic      done;
	lpht_req_t req;
	lpht_rsp_t rsp;

	int mismatches;
	int outstanding;
	int checked;
	int rejects;

	logic [KEY_W-1:0] golden_inv;
	logic [KEY_W-1:0] key_pool [POOL_SIZE];
	logic [KEY_W-1:0] wrap_key [4];

	linear_probe_hash_table #(
		.TABLE_BITS  (TBITS),
		.VALUE_WIDTH (VBITS)
	) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.rsp    (rsp)
	);

	lpht_checker #(
		.TABLE_BITS  (TBITS),
		.VALUE_WIDTH (VBITS)
	) u_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.req         (req),
		.done        (done),
		.rsp         (rsp),
		.mismatches  (mismatches),
		.outstanding (outstanding),
		.checked     (checked),
		.rejects     (rejects)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop well past the slowest legal run
	initial begin
		#100_000_000;
		$display("Timeout waiting for the table to finish");
		$display("Regression FAIL");
		$finish;
	end

	// Key whose home slot is the given one: pick the product, multiply by the inverse
	function automatic logic [KEY_W-1:0] key_at_slot(input int unsigned slot);
		logic [KEY_W-1:0] prod;
		prod = (KEY_W'(slot) << (KEY_W - TBITS)) | ({$urandom, $urandom} >> TBITS);
		return prod * golden_inv;
	endfunction

	// Present one transaction and hold it until the block takes it
	task automatic issue(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] k,
			input logic [WORD_W-1:0] v);
		req   <= '{operation: op, key: k, value: v};
		start <= 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	// Idle burst, either inside the busy window or right after the block frees up
	task automatic hold_off();
		int n;
		n = $urandom_range(1, 3);
		start <= 1'b0;
		if ($urandom_range(0, 1) == 1) begin
			@(posedge clk);
			while (busy)
				@(posedge clk);
		end
		repeat (n) @(posedge clk);
	endtask

	// Stop sending until every owed result has come back
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	initial begin
		int               r;
		int               waited;
		logic [OP_W-1:0]  op;
		logic [KEY_W-1:0] k;

		start  = 1'b0;
		req    = '0;
		arst_n = 1'b0;

		// Newton iteration for the inverse of the odd multiplier mod 2^64
		golden_inv = GOLDEN_MULT;
		repeat (5) golden_inv = golden_inv * (64'd2 - GOLDEN_MULT * golden_inv);

		for (int j = 0; j < POOL_SIZE; j++) begin
			if (j < 12)
				key_pool[j] = key_at_slot(SLOTS - 1);
			else if (j < 20)
				key_pool[j] = key_at_slot(0);
			else if (j < 32)
				key_pool[j] = key_at_slot(SLOTS / 2 + j % 3);
			else
				key_pool[j] = {$urandom, $urandom};
		end
		for (int j = 0; j < 4; j++)
			wrap_key[j] = key_at_slot(SLOTS - 1);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty table, extreme keys and values, unused code
		issue(OP_LOOKUP, '0, '0);
		issue(OP_DELETE, '0, '1);
		issue(OP_INSERT, '0, '1);
		issue(OP_INSERT, '1, '0);
		issue(OP_LOOKUP, '0, '0);
		issue(OP_LOOKUP, '1, '1);
		issue(OP_NONE, '1, '1);
		issue(OP_NONE, '0, '0);

		// Directed: chain at the last slot wraps to slot 0
		issue(OP_INSERT, wrap_key[0], 32'h1111_1111);
		issue(OP_INSERT, wrap_key[1], 32'h2222_2222);
		issue(OP_INSERT, wrap_key[2], 32'h3333_3333);
		issue(OP_LOOKUP, wrap_key[2], '0);
		// hole in front of a live key, then update past the hole
		issue(OP_DELETE, wrap_key[0], '0);
		issue(OP_INSERT, wrap_key[2], 32'hA5A5_5A5A);
		issue(OP_LOOKUP, wrap_key[2], '0);
		// new key reuses the hole
		issue(OP_INSERT, wrap_key[3], 32'h4444_4444);
		issue(OP_LOOKUP, wrap_key[3], '0);
		issue(OP_LOOKUP, wrap_key[0], '0);
		issue(OP_DELETE, wrap_key[1], '0);
		issue(OP_LOOKUP, wrap_key[1], '0);
		issue(OP_DELETE, wrap_key[1], '0);
		issue(OP_INSERT, '0, 32'h8000_0001);
		issue(OP_LOOKUP, '0, '0);
		drain();

		// Random mix over a pool of colliding and plain keys, back to back at the end
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			r = $urandom_range(0, 99);
			if (r < 40)
				op = OP_INSERT;
			else if (r < 70)
				op = OP_LOOKUP;
			else if (r < 95)
				op = OP_DELETE;
			else
				op = OP_NONE;
			if ($urandom_range(0, 3) != 0)
				k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
			else
				k = {$urandom, $urandom};
			issue(op, k, $urandom);
			if (i % 150 == 149)
				drain();
			else if (i < RANDOM_ITEMS - CALM_ITEMS && $urandom_range(0, 2) == 0)
				hold_off();
		end
		start <= 1'b0;

		// Wait for the last results, bounded by a few full laps
		waited = 0;
		@(posedge clk);
		while (outstanding != 0 && waited < 4 * SLOTS + 100) begin
			@(posedge clk);
			waited++;
		end

		if (outstanding != 0) begin
			$display("Timeout: %0d results never arrived", outstanding);
			$display("Regression FAIL");
		end else begin
			repeat (SLOTS + 16) @(posedge clk);
			$display("Checked %0d transactions: corner keys, wrapping collision chains,",
				checked);
			$display("hole reuse and a random mix of colliding keys; %0d inserts refused.",
				rejects);
			if (mismatches == 0 && outstanding == 0)
				$display("Regression PASS");
			else
				$display("Regression FAIL");
		end
		$finish;
	end

endmodule

/* files.f */
rtl/core/lpht_pkg.sv
rtl/core/linear_probe_hash_table.sv
rtl/core/lpht_checker.sv
tb/lpht_checker.sv
tb/tb_top.sv
